@@ design/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication or plain property every cycle
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a trigger is followed in the next cycle by a consequence
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ design/ppfb_pkg.sv @@
package ppfb_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int BYTE_W = 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              copied;
    logic              last;
    logic              new_pending;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic rd_start;
    logic out_load;
    logic out_data;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic any_new;
  } stat_t;

endpackage

@@ design/ppfb_ram.sv @@
module ppfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/ppfb_ctrl.sv @@
module ppfb_ctrl import ppfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int IDX_W = $clog2(FRAME_BYTES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             action,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  stat_t            stat,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] rd_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             accept;
  logic             read_done;

  always_comb begin
    out_free  = !rsp_valid || rsp_ready;
    req_ready = (state == S_IDLE) && out_free;
    accept    = req_valid && req_ready;
    read_done = (state == S_READ) && out_free && (idx == LAST_IDX);
    cmd       = '0;
    rd_idx    = '0;
    if (accept) begin
      if (action == ACT_WRITE) begin
        cmd.wr       = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_last = 1'b1;
      end else if (stat.any_new) begin
        cmd.rd_start = 1'b1;
      end else begin
        cmd.out_load = 1'b1;
        cmd.out_last = 1'b1;
      end
    end
    if (state == S_READ) begin
      // advance the read address only when the byte in flight is taken
      if (out_free) begin
        cmd.out_load = 1'b1;
        cmd.out_data = 1'b1;
        cmd.out_last = (idx == LAST_IDX);
        rd_idx       = idx + 1'b1;
      end else begin
        rd_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      idx <= rd_idx;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.rd_start) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (read_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/ppfb_dp.sv @@
module ppfb_dp import ppfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int IDX_W = $clog2(FRAME_BYTES),
  localparam int CNT_W = $clog2(FRAME_BYTES + 1),
  localparam int ADDR_W = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [BYTE_W-1:0] data_byte,
  input  cmd_t              cmd,
  input  logic [IDX_W-1:0]  rd_idx,
  output stat_t             stat,
  output out_item_t         rsp
);

  logic [BYTE_W-1:0] command_byte;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  logic              select_a;
  logic              select_a_next;
  logic              new_a;
  logic              new_a_next;
  logic              new_b;
  logic              new_b_next;
  logic              rd_bank;
  logic              rd_bank_next;
  logic              sel_new;
  logic              full;
  logic              hit;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // bank A sits at the lower half of the RAM, bank B at the upper half
  always_comb begin
    sel_new         = select_a ? new_a : new_b;
    full            = (fill_count == CNT_W'(FRAME_BYTES));
    hit             = (data_byte == command_byte);
    fill_count_next = fill_count;
    select_a_next   = select_a;
    new_a_next      = new_a;
    new_b_next      = new_b;
    we              = 1'b0;
    wr_addr         = {~select_a, fill_count[IDX_W-1:0]};
    if (cmd.wr && !sel_new) begin
      if (full) begin
        fill_count_next = '0;
        select_a_next   = ~select_a;
        if (select_a) begin
          new_a_next = 1'b1;
        end else begin
          new_b_next = 1'b1;
        end
        if (hit) begin
          we              = 1'b1;
          wr_addr         = {select_a, IDX_W'(0)};
          fill_count_next = CNT_W'(1);
        end
      end else if (fill_count != '0 || hit) begin
        we              = 1'b1;
        fill_count_next = fill_count + 1'b1;
      end
    end
    if (cmd.rd_start) begin
      if (new_a) begin
        new_a_next = 1'b0;
      end else begin
        new_b_next = 1'b0;
      end
    end
    rd_bank_next = cmd.rd_start ? ~new_a : rd_bank;
    rd_addr      = {rd_bank_next, rd_idx};
    stat.any_new = new_a || new_b;
  end

  ppfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** ADDR_W)
  ) bank_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      command_byte <= '0;
      fill_count   <= '0;
      select_a     <= 1'b1;
      new_a        <= 1'b0;
      new_b        <= 1'b0;
      rd_bank      <= 1'b0;
    end else begin
      if (cfg_we) begin
        command_byte <= cfg_wdata;
      end
      fill_count <= fill_count_next;
      select_a   <= select_a_next;
      new_a      <= new_a_next;
      new_b      <= new_b_next;
      rd_bank    <= rd_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.out_byte    <= cmd.out_data ? rd_data : '0;
      rsp.copied      <= cmd.out_data;
      rsp.last        <= cmd.out_last;
      rsp.new_pending <= new_a_next || new_b_next;
    end
  end

endmodule

@@ design/ping_pong_frame_buffer_top.sv @@
// channel | signals                       | direction
// req     | req_valid, req_ready, req     | in  (action, data_byte)
// rsp     | rsp_valid, rsp_ready, rsp     | out (out_byte, copied, last, new_pending)
// cfg     | cfg_we, cfg_wdata             | in  (command_byte)
//
// A write item gives one result from the output register.
// A read item of a new bank gives FRAME_BYTES results, one per cycle while rsp_ready
// holds, after the registered RAM read; the single RAM read port sets this pace.
// A read with no new bank gives one empty, final result.
// rst is synchronous; no item is taken while a read streams or rsp stalls.
`include "assert_macros.svh"

module ping_pong_frame_buffer_top import ppfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  in_item_t          req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output out_item_t         rsp,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] rd_idx;

  ppfb_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .action    (req.action),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

  ppfb_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .data_byte (req.data_byte),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .stat      (stat),
    .rsp       (rsp)
  );

  `ASSERT_NEXT(a_write_result, req_valid && req_ready && req.action == ACT_WRITE, rsp_valid && rsp.last && !rsp.copied, "write item must give one final empty result")
  `ASSERT_CLK(a_empty_zero, rsp_valid && !rsp.copied |-> rsp.last && rsp.out_byte == '0, "empty result must be final and zero")
  `ASSERT_CLK(a_stream_block, rsp_valid && rsp.copied && !rsp.last |-> !req_ready, "item taken while a bank streams")

endmodule

@@ tb/ping_pong_frame_buffer_top_tb.sv @@
`timescale 1ns / 100ps

module ping_pong_frame_buffer_top_tb;
  import ppfb_pkg::*;

  localparam int FRAME = FRAME_BYTES_DEF;
  localparam int RUN_LIMIT_NS = 30_000_000;
  localparam int PHASE_ITEMS = 85;
  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {BANK_READY, BANK_WRITING, BANK_NEW} bank_state_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t rsp;
  } stim_row_t;

  localparam out_item_t NO_DATA = '{out_byte: 8'h00, copied: 1'b0, last: 1'b1,
                                    new_pending: 1'b0};
  localparam out_item_t FROM_MODEL = '0;

  localparam int DIR_ROWS = 12;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{ACT_READ,  8'hFF}, 1'b1, NO_DATA},
    '{'{ACT_WRITE, 8'hFF}, 1'b1, NO_DATA},
    '{'{ACT_WRITE, 8'h01}, 1'b1, NO_DATA},
    '{'{ACT_WRITE, 8'h00}, 1'b1, NO_DATA},
    '{'{ACT_WRITE, 8'hFF}, 1'b0, FROM_MODEL},
    '{'{ACT_WRITE, 8'h00}, 1'b0, FROM_MODEL},
    '{'{ACT_READ,  8'h00}, 1'b1, NO_DATA},
    '{'{ACT_WRITE, 8'h80}, 1'b0, FROM_MODEL},
    '{'{ACT_WRITE, 8'h7F}, 1'b0, FROM_MODEL},
    '{'{ACT_WRITE, 8'h55}, 1'b0, FROM_MODEL},
    '{'{ACT_WRITE, 8'hAA}, 1'b0, FROM_MODEL},
    '{'{ACT_READ,  8'h55}, 1'b0, FROM_MODEL}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  in_item_t          req;
  logic              rsp_valid;
  logic              rsp_ready;
  out_item_t         rsp;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  logic [BYTE_W-1:0] bank_copy [2][FRAME];
  int                fill_copy;
  logic              sel_a_copy;
  bank_state_t       bank_state [2];
  logic [BYTE_W-1:0] cmd_copy;
  out_item_t         step_rsp [FRAME];
  int                step_cnt;
  out_item_t         rsp_due [$];
  logic              burst_mode;

  int fail_count = 0;
  int item_count = 0;
  int result_count = 0;
  int stream_count = 0;
  int empty_reads = 0;
  int dropped_writes = 0;
  int switch_onto_new = 0;
  int cfg_count = 0;

  ping_pong_frame_buffer_top #(
    .FRAME_BYTES(FRAME)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 7) == 0) return cmd_copy;
    return v[BYTE_W-1:0];
  endfunction

  task automatic buffer_step(input in_item_t it);
    int   cur;
    int   oth;
    int   src;
    int   i;
    logic any_new;
    step_cnt = 1;
    src = -1;
    if (it.action == ACT_WRITE) begin
      cur = sel_a_copy ? 0 : 1;
      oth = 1 - cur;
      if (bank_state[cur] == BANK_NEW) begin
        dropped_writes++;
      end else if (fill_copy >= FRAME) begin
        // full bank: switch and maybe start the next frame in the other bank
        fill_copy = 0;
        bank_state[cur] = BANK_NEW;
        sel_a_copy = ~sel_a_copy;
        if (bank_state[oth] == BANK_NEW) switch_onto_new++;
        if (it.data_byte == cmd_copy) begin
          bank_copy[oth][0] = it.data_byte;
          fill_copy = 1;
        end
      end else begin
        bank_state[cur] = BANK_WRITING;
        if (fill_copy != 0 || it.data_byte == cmd_copy) begin
          bank_copy[cur][fill_copy] = it.data_byte;
          fill_copy++;
        end
      end
    end else if (bank_state[0] == BANK_NEW) begin
      src = 0;
      bank_state[0] = BANK_READY;
    end else if (bank_state[1] == BANK_NEW) begin
      src = 1;
      bank_state[1] = BANK_READY;
    end
    any_new = (bank_state[0] == BANK_NEW) || (bank_state[1] == BANK_NEW);
    if (src < 0) begin
      step_rsp[0] = '{out_byte: 8'h00, copied: 1'b0, last: 1'b1, new_pending: any_new};
      if (it.action == ACT_READ) empty_reads++;
    end else begin
      stream_count++;
      step_cnt = FRAME;
      for (i = 0; i < FRAME; i++) begin
        step_rsp[i] = '{out_byte: bank_copy[src][i], copied: 1'b1,
                        last: (i == FRAME - 1) ? 1'b1 : 1'b0, new_pending: any_new};
      end
    end
  endtask

  task automatic send_item(input logic action, input logic [BYTE_W-1:0] data,
                           input logic typed, input out_item_t typed_rsp);
    int       gap;
    int       i;
    in_item_t it;
    it.action = action;
    it.data_byte = data;
    gap = burst_mode ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    item_count++;
    buffer_step(it);
    if (typed) begin
      rsp_due.push_back(typed_rsp);
    end else begin
      for (i = 0; i < step_cnt; i++) rsp_due.push_back(step_rsp[i]);
    end
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
  endtask

  task automatic set_command(input logic [BYTE_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cmd_copy = value;
    cfg_count++;
  endtask

  task automatic write_frame(input int tail);
    send_item(ACT_WRITE, cmd_copy, 1'b0, FROM_MODEL);
    repeat (tail) send_item(ACT_WRITE, rand_byte(), 1'b0, FROM_MODEL);
  endtask

  task automatic random_op();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    v = $urandom;
    burst_mode = ($urandom_range(0, 3) == 0);
    if (r < 40) begin
      write_frame(FRAME - 1);
    end else if (r < 52) begin
      // fill both banks, then switch back onto the unread one
      write_frame(FRAME - 1);
      write_frame(FRAME - 1);
      send_item(ACT_WRITE, cmd_copy, 1'b0, FROM_MODEL);
      repeat ($urandom_range(0, 3)) send_item(ACT_WRITE, rand_byte(), 1'b0, FROM_MODEL);
    end else if (r < 72) begin
      send_item(ACT_READ, rand_byte(), 1'b0, FROM_MODEL);
    end else if (r < 84) begin
      send_item(ACT_WRITE, v[BYTE_W-1:0], 1'b0, FROM_MODEL);
    end else if (r < 94) begin
      write_frame($urandom_range(0, 10));
    end else begin
      drain_results();
    end
    burst_mode = 1'b0;
  endtask

  initial begin : rsp_pacing
    int run;
    int hold;
    rsp_ready <= 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      rsp_ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    out_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      result_count++;
      if (rsp_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result at %0t: byte %02h copied %b last %b pending %b",
                   $realtime, rsp.out_byte, rsp.copied, rsp.last, rsp.new_pending);
      end else begin
        want = rsp_due.pop_front();
        if (rsp.out_byte !== want.out_byte || rsp.copied !== want.copied ||
            rsp.last !== want.last || rsp.new_pending !== want.new_pending) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch at %0t: want byte %02h copied %b last %b pending %b,",
                     $realtime, want.out_byte, want.copied, want.last, want.new_pending,
                     " got %02h %b %b %b",
                     rsp.out_byte, rsp.copied, rsp.last, rsp.new_pending);
        end
      end
    end
  end

  initial begin : stimulus
    int          k;
    int          phase;
    int          start;
    logic [7:0]  phase_cmd;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    burst_mode = 1'b0;
    for (k = 0; k < FRAME; k++) begin
      bank_copy[0][k] = '0;
      bank_copy[1][k] = '0;
    end
    fill_copy = 0;
    sel_a_copy = 1'b1;
    bank_state[0] = BANK_READY;
    bank_state[1] = BANK_READY;
    cmd_copy = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_command(8'h00);
    for (k = 0; k < DIR_ROWS; k++)
      send_item(DIRECTED[k].item.action, DIRECTED[k].item.data_byte,
                DIRECTED[k].typed, DIRECTED[k].rsp);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: phase_cmd = 8'hFF;
        1: phase_cmd = 8'($urandom_range(1, 254));
        default: phase_cmd = 8'h00;
      endcase
      set_command(phase_cmd);
      start = item_count;
      while (item_count - start < PHASE_ITEMS) random_op();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (rsp_due.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", rsp_due.size());
    end

    $display("covered %0d items over %0d command byte settings:", item_count, cfg_count,
             " %0d bank streams, %0d empty reads", stream_count, empty_reads);
    $display("checked %0d results; %0d writes dropped on an unread bank, %0d switches onto one",
             result_count, dropped_writes, switch_onto_new);
    if (fail_count == 0) begin
      $display("ping_pong_frame_buffer_top_tb OK");
    end else begin
      $display("ping_pong_frame_buffer_top_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("ping_pong_frame_buffer_top_tb NOT OK");
    $finish;
  end

endmodule
